### design/pts_pkg.sv
// Shared types and constants for the periodic timer slot table.
package pts_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int QUEUE_DEPTH   = 2;
  // wide enough to hold any slot number or slot count in range
  localparam int SLOT_CMP_W    = 9;

  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 16;
  localparam int STATUS_W = 2;
  localparam int TICK_W   = 32;

  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRED  = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ADD,
    OP_REMOVE,
    OP_ADD_BAD,
    OP_REM_BAD
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
  } request_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_FLUSH
  } back_state_t;

endpackage

### design/pts_ram.sv
// Generic simple dual-port RAM with registered read.
module pts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/pts_front.sv
// Front end: takes requests and classifies them for the back end.
module pts_front import pts_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                start,
  input  queue_status_t       q_stat,
  input  logic [ACTION_W-1:0] action,
  input  logic [SLOT_W-1:0]   slot_id,
  input  logic [PERIOD_W-1:0] period,
  output logic                push,
  output request_t            req
);

  logic [SLOT_CMP_W-1:0] slot_wide;
  logic                  in_range;
  logic                  known;

  assign slot_wide = SLOT_CMP_W'(slot_id);
  assign in_range  = slot_wide < SLOT_CMP_W'(SLOTS);

  always_comb begin
    req.slot   = slot_id;
    req.period = period;
    req.op     = OP_TICK;
    known      = 1'b1;
    case (action)
      ACT_TICK:   req.op = OP_TICK;
      ACT_ADD:    req.op = in_range ? OP_ADD : OP_ADD_BAD;
      ACT_REMOVE: req.op = in_range ? OP_REMOVE : OP_REM_BAD;
      default:    known  = 1'b0;
    endcase
  end

  // unused action codes are swallowed here
  assign push = start && !q_stat.full && known;

endmodule

### design/pts_queue.sv
// Short request queue between front and back end.
module pts_queue import pts_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  request_t      push_req,
  input  logic          pop,
  output request_t      head,
  output queue_status_t q_stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  request_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

### design/pts_back.sv
// Back end: executes add/remove and scans slots on each tick.
module pts_back import pts_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  request_t            head,
  input  queue_status_t       q_stat,
  output logic                pop,
  output logic                valid,
  output logic                kind,
  output logic [SLOT_W-1:0]   slot_out,
  output logic [STATUS_W-1:0] status,
  output logic                last_of_run
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  back_state_t state;
  back_state_t state_next;

  logic [TICK_W-1:0] tick_count;
  logic [SLOTS-1:0]  armed;
  logic [IDX_W-1:0]  idx;
  logic              pend_valid;
  logic [IDX_W-1:0]  pend_slot;

  logic [SLOT_CMP_W-1:0] head_wide;
  logic [IDX_W-1:0]      head_idx;
  logic [SLOT_CMP_W-1:0] pend_wide;

  logic [IDX_W-1:0]    wr_addr;
  logic [IDX_W-1:0]    rd_addr;
  logic                lf_we;
  logic                per_we;
  logic [TICK_W-1:0]   lf_rd;
  logic [PERIOD_W-1:0] per_rd;
  logic [TICK_W-1:0]   elapsed;
  logic                fire;
  logic                arm_set;
  logic                arm_clr;

  logic                res_emit;
  logic                res_kind;
  logic [SLOT_W-1:0]   res_slot;
  logic [STATUS_W-1:0] res_status;
  logic                res_last;

  assign head_wide = SLOT_CMP_W'(head.slot);
  assign head_idx  = head_wide[IDX_W-1:0];
  assign pend_wide = SLOT_CMP_W'(pend_slot);

  // wrap-safe elapsed time
  assign elapsed = tick_count - lf_rd;
  assign fire    = armed[idx] && (elapsed >= TICK_W'(per_rd));

  pts_ram #(.WIDTH(TICK_W), .DEPTH(SLOTS), .ADDR_W(IDX_W)) u_last_fire (
    .clk   (clk),
    .we    (lf_we),
    .waddr (wr_addr),
    .wdata (tick_count),
    .raddr (rd_addr),
    .rdata (lf_rd)
  );

  pts_ram #(.WIDTH(PERIOD_W), .DEPTH(SLOTS), .ADDR_W(IDX_W)) u_period (
    .clk   (clk),
    .we    (per_we),
    .waddr (wr_addr),
    .wdata (head.period),
    .raddr (rd_addr),
    .rdata (per_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_stat.empty && head.op == OP_TICK) begin
          state_next = B_SCAN;
        end
      end
      B_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = B_FLUSH;
        end
      end
      B_FLUSH: state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    lf_we      = 1'b0;
    per_we     = 1'b0;
    arm_set    = 1'b0;
    arm_clr    = 1'b0;
    wr_addr    = head_idx;
    rd_addr    = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    res_emit   = 1'b0;
    res_kind   = KIND_STATUS;
    res_slot   = head.slot;
    res_status = ST_OK;
    res_last   = 1'b1;
    case (state)
      B_IDLE: begin
        rd_addr = '0;
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (head.op)
            OP_ADD: begin
              res_emit = 1'b1;
              if (armed[head_idx]) begin
                res_status = ST_DUPLICATE;
              end else begin
                lf_we   = 1'b1;
                per_we  = 1'b1;
                arm_set = 1'b1;
              end
            end
            OP_REMOVE: begin
              res_emit = 1'b1;
              if (armed[head_idx]) begin
                arm_clr = 1'b1;
              end else begin
                res_status = ST_EMPTY;
              end
            end
            OP_ADD_BAD: begin
              res_emit   = 1'b1;
              res_status = ST_DUPLICATE;
            end
            OP_REM_BAD: begin
              res_emit   = 1'b1;
              res_status = ST_EMPTY;
            end
            default: ;
          endcase
        end
      end
      B_SCAN: begin
        // a firing is held back until we know whether another follows
        res_kind = KIND_FIRED;
        res_slot = pend_wide[SLOT_W-1:0];
        res_last = 1'b0;
        if (fire) begin
          lf_we    = 1'b1;
          wr_addr  = idx;
          res_emit = pend_valid;
        end
      end
      B_FLUSH: begin
        res_kind = KIND_FIRED;
        res_slot = pend_wide[SLOT_W-1:0];
        res_emit = pend_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      tick_count <= '0;
      armed      <= '0;
      idx        <= '0;
      pend_valid <= 1'b0;
      valid      <= 1'b0;
    end else begin
      state <= state_next;
      valid <= res_emit;
      if (arm_set) begin
        armed[head_idx] <= 1'b1;
      end
      if (arm_clr) begin
        armed[head_idx] <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          idx        <= '0;
          pend_valid <= 1'b0;
          if (pop && head.op == OP_TICK) begin
            tick_count <= tick_count + 1'b1;
          end
        end
        B_SCAN: begin
          idx <= idx + 1'b1;
          if (fire) begin
            pend_valid <= 1'b1;
          end
        end
        B_FLUSH: pend_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_SCAN && fire) begin
      pend_slot <= idx;
    end
    if (res_emit) begin
      kind        <= res_kind;
      slot_out    <= res_slot;
      status      <= res_status;
      last_of_run <= res_last;
    end
  end

endmodule

### design/periodic_timer_slot_table_top.sv
// Periodic timer slot table: top level.
//
// Requests (tick, add slot, remove slot) enter on start while busy is low,
// with action, slot_id and period. Unused action codes are dropped.
// Results leave on valid, one cycle each, with kind, slot_out, status and
// last_of_run; the receiver must take every result as it appears.
// The front end classifies each request into a two-entry queue; busy is
// high while that queue is full. The back end works one request at a time.
// Add and remove give their single status result in the cycle after the
// idle back end pops them from the head of the queue. A tick scans the
// slots one per cycle through the last-fire and period RAM read port;
// firings come out in ascending slot order, the last one of the tick
// marked, and a tick on which nothing fires gives nothing.
// Reset (synchronous) empties the queue, disarms all slots and zeroes the
// tick counter; RAM contents are left as they are, as a slot is only read
// after an add has written it. There is no clearing pass.
module periodic_timer_slot_table_top import pts_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] action,
  input  logic [SLOT_W-1:0]   slot_id,
  input  logic [PERIOD_W-1:0] period,
  output logic                valid,
  output logic                kind,
  output logic [SLOT_W-1:0]   slot_out,
  output logic [STATUS_W-1:0] status,
  output logic                last_of_run
);

  queue_status_t q_stat;
  request_t      push_req;
  request_t      head;
  logic          push;
  logic          pop;

  assign busy = q_stat.full;

  pts_front #(.SLOTS(SLOTS)) u_front (
    .start   (start),
    .q_stat  (q_stat),
    .action  (action),
    .slot_id (slot_id),
    .period  (period),
    .push    (push),
    .req     (push_req)
  );

  pts_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  pts_back #(.SLOTS(SLOTS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .valid       (valid),
    .kind        (kind),
    .slot_out    (slot_out),
    .status      (status),
    .last_of_run (last_of_run)
  );

endmodule

### design/pts_checker.sv
// Port-level checks for the periodic timer slot table.
module pts_checker import pts_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                busy,
  input logic                valid,
  input logic                kind,
  input logic [STATUS_W-1:0] status,
  input logic                last_of_run
);

  // reset leaves no result pending and the queue open
  a_reset_quiet: assert property (@(posedge clk) rst |=> !valid && !busy)
    else $error("result or busy right after reset");

  // a command status is always the only result of its request
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_STATUS |-> last_of_run)
    else $error("command status not marked last");

  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_FIRED |-> status == ST_OK)
    else $error("firing with non-ok status");

  // a tick's run of firings is not broken by a command status
  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_FIRED && !last_of_run |=> !(valid && kind == KIND_STATUS))
    else $error("command status inside a firing run");

endmodule

bind periodic_timer_slot_table_top pts_checker u_pts_checker (.*);
